// ----- rtl/cpmnc_pkg.sv -----
// ----------------------------------------------------------------------------
// cpmnc_pkg: shared types and constants of the challenge multiplier
// Command and result codes, challenge sign codes, modulus and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package cpmnc_pkg;

  localparam int unsigned VALUE_W = 23;
  localparam int unsigned BOUND_W = 22;
  localparam int unsigned INDEX_W = 8;

  localparam logic [VALUE_W-1:0] MODULUS      = 23'd8380417;
  localparam logic [VALUE_W-1:0] HALF_MODULUS = 23'd4190208;
  localparam logic [BOUND_W-1:0] NORM_RESET   = 22'((1 << 19) - 196);

  typedef enum logic [1:0] {
    CMD_LOAD_CHAL = 2'd0,
    CMD_LOAD_SEC  = 2'd1,
    CMD_COMPUTE   = 2'd2,
    CMD_READ      = 2'd3
  } cmd_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_COEFF  = 1'b1
  } kind_e;

  // Challenge coefficient codes; the remaining code reads as zero.
  localparam logic [1:0] CH_ZERO = 2'b00;
  localparam logic [1:0] CH_POS  = 2'b01;
  localparam logic [1:0] CH_NEG  = 2'b11;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RDWAIT = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_DRAIN  = 4'b1000
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/challenge_poly_mul_norm_check.sv -----
// ----------------------------------------------------------------------------
// challenge_poly_mul_norm_check: negacyclic challenge product with norm check
// Stores challenge and secret coefficients, forms their product modulo
// X^N + 1 and q = 8380417, checks the infinity norm and serves readback.
// ----------------------------------------------------------------------------
// Flow: a load gives no result; a read passes through prod_rd_q and ST_RDWAIT to the
//   output register; a compute sweeps all pairs, then drains to the status result.
// Throughput: the compute sweep makes one multiply-accumulate per cycle, set
//   by the single read port of the secret memory.
// Reset: control and norm flag clear at once and the norm bound returns to
//   2^19 - 196; coefficient memories are not cleared and hold garbage until written.
`default_nettype none

module challenge_poly_mul_norm_check #(
  parameter int unsigned COEFF_COUNT = 256
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Input transactions
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [7:0] index, [30:8] value, [31] zero
  input  wire  [1:0]  s_axis_tuser,   // [1:0] cmd
  // Result transactions
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] coeff_index, [30:8] coeff, [31] norm_ok
  output logic        m_axis_tuser,   // [0] kind
  // Norm bound write channel
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [21:0] cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(COEFF_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(COEFF_COUNT - 1);
  localparam logic [IDX_W:0]   N_EXT    = (IDX_W + 1)'(COEFF_COUNT);

  localparam int unsigned VW = cpmnc_pkg::VALUE_W;
  localparam int unsigned BW = cpmnc_pkg::BOUND_W;

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  cpmnc_pkg::cmd_e    in_cmd;
  logic [7:0]         in_index;
  logic [VW-1:0]      in_value;
  logic [IDX_W-1:0]   in_addr;
  logic               in_range;
  logic               in_is_load;
  logic               in_fire;

  assign in_cmd     = cpmnc_pkg::cmd_e'(s_axis_tuser);
  assign in_index   = s_axis_tdata[7:0];
  assign in_value   = s_axis_tdata[30:8];
  assign in_addr    = IDX_W'(in_index);
  assign in_range   = {24'd0, in_index} < 32'(COEFF_COUNT);
  assign in_is_load = (in_cmd == cpmnc_pkg::CMD_LOAD_CHAL) ||
                      (in_cmd == cpmnc_pkg::CMD_LOAD_SEC);

  cpmnc_pkg::state_e state_q, state_d;
  logic              m_valid_q;

  // Take a read or compute only when the output slot is free or freeing now;
  // loads pass regardless of a waiting result.
  assign s_axis_tready = (state_q == cpmnc_pkg::ST_IDLE) &&
                         (!m_valid_q || m_axis_tready || in_is_load);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Configuration is only to be written while idle; the block itself does not enforce it, so always take it.
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Sweep counters: k is the product position, i the challenge position
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0] k_q, i_q;
  logic [IDX_W:0]   sec_full;
  logic [IDX_W-1:0] sec_addr;
  logic             wrap;

  // Secret index (k - i) mod N; a wrapped pair picks up a minus sign.
  assign wrap     = i_q > k_q;
  assign sec_full = wrap ? ({1'b0, k_q} + N_EXT - {1'b0, i_q})
                         : ({1'b0, k_q} - {1'b0, i_q});
  assign sec_addr = sec_full[IDX_W-1:0];

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  logic [1:0]    chal_mem [COEFF_COUNT];
  logic [VW-1:0] sec_mem  [COEFF_COUNT];
  logic [VW-1:0] prod_mem [COEFF_COUNT];

  logic [1:0]    chal_rd_q;
  logic [VW-1:0] sec_rd_q;
  logic [VW-1:0] prod_rd_q;

  logic [1:0]    chal_code;
  assign chal_code = in_value[VW-1] ? cpmnc_pkg::CH_NEG :
                     (in_value == '0) ? cpmnc_pkg::CH_ZERO : cpmnc_pkg::CH_POS;

  always_ff @(posedge clk_i) begin
    if (in_fire && in_range && (in_cmd == cpmnc_pkg::CMD_LOAD_CHAL)) begin
      chal_mem[in_addr] <= chal_code;
    end
    chal_rd_q <= chal_mem[i_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_range && (in_cmd == cpmnc_pkg::CMD_LOAD_SEC)) begin
      sec_mem[in_addr] <= in_value;
    end
    sec_rd_q <= sec_mem[sec_addr];
  end

  logic             wb_valid_q;
  logic [IDX_W-1:0] wb_k_q;
  logic [VW-1:0]    wb_centered;

  always_ff @(posedge clk_i) begin
    if (wb_valid_q) begin
      prod_mem[wb_k_q] <= wb_centered;
    end
    prod_rd_q <= prod_mem[in_addr];
  end

  // --------------------------------------------------------------------------
  // Accumulate stage: data of pair (i, k) arrives in the cycle after issue
  // --------------------------------------------------------------------------
  logic             acc_valid_q;
  logic             acc_first_q, acc_last_q, acc_neg_q;
  logic [IDX_W-1:0] acc_k_q;
  logic [VW-1:0]    acc_q, acc_d;

  logic [VW:0]      sec_ext;
  logic [VW:0]      term;
  logic             term_zero, term_flip;
  logic [VW-1:0]    acc_base;
  logic [VW+1:0]    sum;

  assign sec_ext   = {sec_rd_q[VW-1], sec_rd_q};
  assign term_zero = (chal_rd_q != cpmnc_pkg::CH_POS) && (chal_rd_q != cpmnc_pkg::CH_NEG);
  assign term_flip = (chal_rd_q == cpmnc_pkg::CH_NEG) ^ acc_neg_q;
  assign term      = term_zero ? '0 : (term_flip ? (~sec_ext + 1'b1) : sec_ext);
  assign acc_base  = acc_first_q ? '0 : acc_q;
  assign sum       = {2'b00, acc_base} + {term[VW], term};

  // Keep the running sum reduced to 0..q-1; one correction suffices since
  // every term is smaller than q in magnitude.
  always_comb begin
    if (sum[VW+1]) begin
      acc_d = VW'(sum + {2'b00, cpmnc_pkg::MODULUS});
    end else if (sum >= {2'b00, cpmnc_pkg::MODULUS}) begin
      acc_d = VW'(sum - {2'b00, cpmnc_pkg::MODULUS});
    end else begin
      acc_d = sum[VW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Write-back stage: center, store and check one finished coefficient
  // --------------------------------------------------------------------------
  logic [VW-1:0] wb_res_q;
  logic [BW-1:0] wb_abs;
  logic          wb_ok;
  logic [BW-1:0] norm_bound_q;
  logic          run_ok_q;
  logic          norm_flag_q;
  logic          final_ok;

  assign wb_centered = (wb_res_q > cpmnc_pkg::HALF_MODULUS) ?
                       (wb_res_q - cpmnc_pkg::MODULUS) : wb_res_q;
  assign wb_abs      = (wb_res_q > cpmnc_pkg::HALF_MODULUS) ?
                       BW'(cpmnc_pkg::MODULUS - wb_res_q) : BW'(wb_res_q);
  assign wb_ok       = wb_abs < norm_bound_q;
  assign final_ok    = run_ok_q && wb_ok;

  logic wb_done;
  assign wb_done = wb_valid_q && (wb_k_q == LAST_IDX);

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cpmnc_pkg::ST_IDLE: begin
        if (in_fire && (in_cmd == cpmnc_pkg::CMD_COMPUTE)) begin
          state_d = cpmnc_pkg::ST_SWEEP;
        end else if (in_fire && (in_cmd == cpmnc_pkg::CMD_READ) && in_range) begin
          state_d = cpmnc_pkg::ST_RDWAIT;
        end
      end
      cpmnc_pkg::ST_RDWAIT: state_d = cpmnc_pkg::ST_IDLE;
      cpmnc_pkg::ST_SWEEP: begin
        if ((i_q == LAST_IDX) && (k_q == LAST_IDX)) begin
          state_d = cpmnc_pkg::ST_DRAIN;
        end
      end
      cpmnc_pkg::ST_DRAIN: begin
        if (wb_done) begin
          state_d = cpmnc_pkg::ST_IDLE;
        end
      end
      default: state_d = cpmnc_pkg::ST_IDLE;
    endcase
  end

  logic sweeping;
  assign sweeping = (state_q == cpmnc_pkg::ST_SWEEP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cpmnc_pkg::ST_IDLE;
      i_q          <= '0;
      k_q          <= '0;
      acc_valid_q  <= 1'b0;
      wb_valid_q   <= 1'b0;
      run_ok_q     <= 1'b1;
      norm_flag_q  <= 1'b0;
      norm_bound_q <= cpmnc_pkg::NORM_RESET;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        norm_bound_q <= cfg_data_i;
      end

      // Advance i fastest, then k; both rest at zero between sweeps.
      if (sweeping) begin
        if (i_q == LAST_IDX) begin
          i_q <= '0;
          k_q <= (k_q == LAST_IDX) ? '0 : k_q + 1'b1;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end

      acc_valid_q <= sweeping;
      wb_valid_q  <= acc_valid_q && acc_last_q;

      if (in_fire && (in_cmd == cpmnc_pkg::CMD_COMPUTE)) begin
        run_ok_q <= 1'b1;
      end else if (wb_valid_q && !wb_ok) begin
        run_ok_q <= 1'b0;
      end

      if (wb_done) begin
        norm_flag_q <= final_ok;
      end

      // Fill the output slot from a finished compute or a read; drop on take.
      if (wb_done || (state_q == cpmnc_pkg::ST_RDWAIT)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  logic [7:0]      rd_idx_q;
  logic [31:0]     m_data_q;
  cpmnc_pkg::kind_e m_kind_q;

  always_ff @(posedge clk_i) begin
    acc_first_q <= (i_q == '0);
    acc_last_q  <= (i_q == LAST_IDX);
    acc_neg_q   <= wrap;
    acc_k_q     <= k_q;

    if (acc_valid_q) begin
      acc_q <= acc_d;
    end
    if (acc_valid_q && acc_last_q) begin
      wb_res_q <= acc_d;
      wb_k_q   <= acc_k_q;
    end

    if (in_fire) begin
      rd_idx_q <= in_index;
    end

    if (wb_done) begin
      m_kind_q <= cpmnc_pkg::KIND_STATUS;
      m_data_q <= {final_ok, 23'd0, 8'd0};
    end else if (state_q == cpmnc_pkg::ST_RDWAIT) begin
      m_kind_q <= cpmnc_pkg::KIND_COEFF;
      m_data_q <= {norm_flag_q, prod_rd_q, rd_idx_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_kind_q;

endmodule

`default_nettype wire
